// ===== sv/mre_pkg.sv =====
// ---------------------------------------------------------------------------
// mre_pkg
// Types and codes shared by the R-type execute block and its channels.
// ---------------------------------------------------------------------------
package mre_pkg;

    localparam int unsigned XLEN     = 32;
    localparam int unsigned NUM_REGS = 32;
    localparam int unsigned RIDX_W   = $clog2(NUM_REGS);

    // action codes
    localparam logic [1:0] ACT_EXEC   = 2'd0;
    localparam logic [1:0] ACT_LD_REG = 2'd1;
    localparam logic [1:0] ACT_LD_PC  = 2'd2;

    // function field codes
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_NAND = 6'h28;
    localparam logic [5:0] FN_SLT  = 6'h2A;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    localparam logic [XLEN-1:0] PC_STEP = 32'd4;

    typedef struct packed {
        logic [1:0]        action;
        logic [5:0]        func_code;
        logic [RIDX_W-1:0] src_a_sel;
        logic [RIDX_W-1:0] src_b_sel;
        logic [RIDX_W-1:0] dest_sel;
        logic [4:0]        shift_amount;
        logic [XLEN-1:0]   load_value;
    } t_req;

    typedef struct packed {
        logic [XLEN-1:0]   next_pc;
        logic              wrote_reg;
        logic [RIDX_W-1:0] written_index;
        logic [XLEN-1:0]   written_value;
        logic              bad_func;
    } t_rsp;

endpackage

// ===== sv/mre_if.sv =====
// ---------------------------------------------------------------------------
// mre_req_if / mre_rsp_if
// Valid/ready channels carrying instruction beats and result beats.
// ---------------------------------------------------------------------------
interface mre_req_if import mre_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mre_rsp_if import mre_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/mips_r_type_execute.sv =====
// Pipeline: execute stage, then output register. Throughput: one beat per
//   cycle while o_rsp is ready; the register file has two synchronous read
//   ports and one write port, and a write forward covers back-to-back reuse.
// Reset (synchronous, active low): PC zero, register file reads as zero via
//   per-entry valid bits, pipeline and output empty; no clearing pass.
// ---------------------------------------------------------------------------
// mips_r_type_execute
// R-type execute stage with a 32 x 32 register file and a program counter.
// ---------------------------------------------------------------------------
module mips_r_type_execute import mre_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mre_req_if.sink    i_req,
    mre_rsp_if.source  o_rsp
);

    // register file memory and its read data
    logic [XLEN-1:0]     r_mem [NUM_REGS];
    logic [XLEN-1:0]     r_rd_a;
    logic [XLEN-1:0]     r_rd_b;
    logic [NUM_REGS-1:0] r_ent_vld;
    logic                r_va;
    logic                r_vb;

    // execute stage
    logic                r_s1_vld;
    t_req                r_s1;
    logic [XLEN-1:0]     r_pc;

    // last register write, for forwarding
    logic                r_fw_vld;
    logic [RIDX_W-1:0]   r_fw_idx;
    logic [XLEN-1:0]     r_fw_val;

    // output register
    logic                r_out_vld;
    t_rsp                r_out;

    logic                s1_adv;
    logic                in_acc;
    logic [XLEN-1:0]     op_a;
    logic [XLEN-1:0]     op_b;
    logic [XLEN-1:0]     alu_r;
    logic                n_wr;
    logic                n_bad;
    logic [XLEN-1:0]     n_pc;
    t_rsp                n_out;

    assign s1_adv      = !r_out_vld || o_rsp.ready;
    assign i_req.ready = !r_s1_vld || s1_adv;
    assign in_acc      = i_req.valid && i_req.ready;

    // memory read ports, sampled on an accepted beat
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_a <= r_mem[i_req.data.src_a_sel];
            r_rd_b <= r_mem[i_req.data.src_b_sel];
            r_va   <= r_ent_vld[i_req.data.src_a_sel];
            r_vb   <= r_ent_vld[i_req.data.src_b_sel];
            r_s1   <= i_req.data;
        end
    end

    // operand select with forward of the latest write
    always_comb begin
        if (r_fw_vld && r_fw_idx == r_s1.src_a_sel) begin
            op_a = r_fw_val;
        end else begin
            op_a = r_va ? r_rd_a : '0;
        end
        if (r_fw_vld && r_fw_idx == r_s1.src_b_sel) begin
            op_b = r_fw_val;
        end else begin
            op_b = r_vb ? r_rd_b : '0;
        end
    end

    // alu and result beat
    always_comb begin
        alu_r = '0;
        n_wr  = 1'b0;
        n_bad = 1'b0;
        n_pc  = r_pc;
        unique case (r_s1.action)
            ACT_EXEC: begin
                n_wr = 1'b1;
                n_pc = r_pc + PC_STEP;
                unique case (r_s1.func_code)
                    FN_ADD, FN_ADDU: alu_r = op_a + op_b;
                    FN_SUB, FN_SUBU: alu_r = op_a - op_b;
                    FN_AND:  alu_r = op_a & op_b;
                    FN_OR:   alu_r = op_a | op_b;
                    FN_XOR:  alu_r = op_a ^ op_b;
                    FN_NOR:  alu_r = ~(op_a | op_b);
                    FN_NAND: alu_r = ~(op_a & op_b);
                    FN_SLT:  alu_r = {{(XLEN-1){1'b0}}, ($signed(op_a) < $signed(op_b))};
                    FN_SLTU: alu_r = {{(XLEN-1){1'b0}}, (op_a < op_b)};
                    FN_SLL:  alu_r = op_b << r_s1.shift_amount;
                    FN_SRL:  alu_r = op_b >> r_s1.shift_amount;
                    FN_SRA:  alu_r = XLEN'($signed(op_b) >>> r_s1.shift_amount);
                    FN_JR: begin
                        n_wr = 1'b0;
                        n_pc = op_a;
                    end
                    default: begin
                        n_wr  = 1'b0;
                        n_bad = 1'b1;
                        n_pc  = r_pc;
                    end
                endcase
            end
            ACT_LD_REG: begin
                n_wr  = 1'b1;
                alu_r = r_s1.load_value;
            end
            ACT_LD_PC: begin
                n_pc = r_s1.load_value;
            end
            default: begin
                n_pc = r_pc;
            end
        endcase
        n_out.next_pc       = n_pc;
        n_out.wrote_reg     = n_wr;
        n_out.written_index = n_wr ? r_s1.dest_sel : '0;
        n_out.written_value = n_wr ? alu_r : '0;
        n_out.bad_func      = n_bad;
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        if (r_s1_vld && s1_adv && n_wr) begin
            r_mem[r_s1.dest_sel] <= alu_r;
        end
    end

    // forward register and output payload
    always_ff @(posedge i_clk) begin
        if (r_s1_vld && s1_adv) begin
            r_out <= n_out;
            if (n_wr) begin
                r_fw_idx <= r_s1.dest_sel;
                r_fw_val <= alu_r;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pc      <= '0;
            r_fw_vld  <= 1'b0;
            r_ent_vld <= '0;
        end else begin
            if (i_req.ready) begin
                r_s1_vld <= i_req.valid;
            end
            if (s1_adv) begin
                r_out_vld <= r_s1_vld;
            end
            if (r_s1_vld && s1_adv) begin
                r_pc <= n_pc;
                if (n_wr) begin
                    r_fw_vld                  <= 1'b1;
                    r_ent_vld[r_s1.dest_sel]  <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

endmodule

// ===== sv/mre_checker.sv =====
// ---------------------------------------------------------------------------
// mre_checker
// Port-level checks on the result channel of the execute block.
// ---------------------------------------------------------------------------
module mre_checker import mre_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_rsp i_out_data
);

    // no result beat right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result beat valid right after reset");

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result beat changed");

    // no register write reports zero index and value
    a_no_wr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.wrote_reg |->
            i_out_data.written_index == '0 && i_out_data.written_value == '0)
        else $error("index or value set without a register write");

    // bad function never writes; the design also keeps the pc, unchecked here
    a_bad_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.bad_func |-> !i_out_data.wrote_reg)
        else $error("bad function reported a register write");

endmodule

bind mips_r_type_execute mre_checker u_mre_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  (o_rsp.data)
);
